// ===== rtl/core/sqbe_pkg.sv =====
// Shared types, constants and helper functions of the sprite quad batch expander.
package sqbe_pkg;

    // Sprite bound of one frame and the vertex count at which it is reached.
    localparam int MAX_SPRITES_PER_FRAME = 16384;
    localparam int CNT_W                 = 17;
    localparam logic [CNT_W-1:0] VERT_LIMIT       = CNT_W'(4 * MAX_SPRITES_PER_FRAME);
    localparam logic [CNT_W-1:0] VERTS_PER_SPRITE = CNT_W'(4);
    localparam logic [CNT_W-1:0] IDX_PER_SPRITE   = CNT_W'(6);

    // Field widths.
    localparam int KEY_W  = 16;
    localparam int COEF_W = 32;
    localparam int HALF_W = 16;
    localparam int UV_W   = 17;
    localparam int IDX_W  = 16;
    localparam int POS_W  = 32;
    localparam int FRAC_SHIFT = 4;

    // A coefficient times a Q12.4 term, and the corner sums in Q.20.
    localparam int PROD_W = 49;
    localparam int SUM_W  = 52;

    // Stream widths.
    localparam int IN_DATA_W  = 352;
    localparam int OUT_DATA_W = 184;
    localparam int KIND_W     = 2;

    typedef enum logic [KIND_W-1:0] {
        KIND_VERTEX = 2'd0,
        KIND_INDEX  = 2'd1,
        KIND_BATCH  = 2'd2
    } kind_t;

    // Result slots of one command, in emission order.
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] STEP_CLOSE     = 4'd0;
    localparam logic [STEP_W-1:0] STEP_VERT0     = 4'd1;
    localparam logic [STEP_W-1:0] STEP_IDX0      = 4'd5;
    localparam logic [STEP_W-1:0] STEP_IDX_LAST  = 4'd10;
    localparam logic [STEP_W-1:0] STEP_EOF       = 4'd11;

    // Command queue between the front and the back.
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [KEY_W-1:0] mat;
        logic [KEY_W-1:0] lay;
        logic [CNT_W-1:0] first;
        logic [CNT_W-1:0] count;
    } batch_rec_t;

    typedef struct packed {
        logic              has_close;
        logic              has_sprite;
        logic              has_eof;
        logic              ovf;
        batch_rec_t        close_rec;
        batch_rec_t        eof_rec;
        logic [CNT_W-1:0]  vbase;
        logic [HALF_W-1:0] uv_px;
        logic [HALF_W-1:0] uv_py;
        logic [HALF_W-1:0] uv_ex;
        logic [HALF_W-1:0] uv_ey;
    } meta_t;

    typedef struct packed {
        meta_t                  meta;
        logic [3:0][SUM_W-1:0]  sum_x;
        logic [3:0][SUM_W-1:0]  sum_y;
    } cmd_t;

    typedef struct packed {
        logic push_ready;
        logic head_valid;
    } q_status_t;

    // Vertex offset of each entry of the two triangles b,b+1,b+2 and b+2,b+3,b.
    function automatic logic [1:0] ix_offset(input logic [2:0] k);
        logic [1:0] r;
        begin
            unique case (k)
                3'd0:    r = 2'd0;
                3'd1:    r = 2'd1;
                3'd2:    r = 2'd2;
                3'd3:    r = 2'd2;
                3'd4:    r = 2'd3;
                default: r = 2'd0;
            endcase
            return r;
        end
    endfunction

    // Q.20 sum to Q16.16: floor of sum/16 (the half was added earlier), then saturate.
    function automatic logic [POS_W-1:0] sat_pos(input logic [SUM_W-1:0] s);
        logic [SUM_W-FRAC_SHIFT-1:0] q;
        logic [SUM_W-FRAC_SHIFT-POS_W:0] hi;
        logic [POS_W-1:0] r;
        begin
            q  = s[SUM_W-1:FRAC_SHIFT];
            hi = q[SUM_W-FRAC_SHIFT-1:POS_W-1];
            if ((&hi) || !(|hi)) begin
                r = q[POS_W-1:0];
            end
            else if (q[SUM_W-FRAC_SHIFT-1]) begin
                r = {1'b1, {(POS_W-1){1'b0}}};
            end
            else begin
                r = {1'b0, {(POS_W-1){1'b1}}};
            end
            return r;
        end
    endfunction

    // Region position plus the extent when the corner takes it.
    function automatic logic [UV_W-1:0] uv_sum(input logic [HALF_W-1:0] p,
                                               input logic [HALF_W-1:0] e,
                                               input logic              sel);
        logic [UV_W-1:0] r;
        begin
            r = {1'b0, p} + (sel ? {1'b0, e} : {UV_W{1'b0}});
            return r;
        end
    endfunction

endpackage

// ===== rtl/core/sqbe_front.sv =====
// Intake: batch classification, frame counters and the corner position pipeline.
module sqbe_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [sqbe_pkg::IN_DATA_W-1:0] s_axis_tdata,
    input  logic                          s_axis_tlast,
    output logic                          push,
    output sqbe_pkg::cmd_t                push_cmd,
    input  sqbe_pkg::q_status_t           q_status
);
    import sqbe_pkg::*;

    // Batch and frame state.
    logic [KEY_W-1:0] cur_mat_reg, cur_mat_next;
    logic [KEY_W-1:0] cur_lay_reg, cur_lay_next;
    logic             open_reg, open_next;
    logic [CNT_W-1:0] first_reg, first_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] vbase_reg, vbase_next;
    logic             ovf_reg, ovf_next;

    logic en;
    logic accept;

    // Classification of the incoming sprite.
    logic [KEY_W-1:0] in_lay, in_mat;
    logic             in_eof;
    logic             drop, key_diff, close;
    logic [KEY_W-1:0] mat_mid, lay_mid;
    logic [CNT_W-1:0] first_mid, count_mid, vbase_mid;
    logic             open_mid, ovf_mid;
    meta_t            meta_new;

    // Stage A: operands.
    logic                     a_valid_reg, a_valid_next;
    meta_t                    a_meta_reg;
    logic signed [COEF_W-1:0] a_cl_reg [2];
    logic signed [COEF_W-1:0] a_cm_reg [2];
    logic signed [COEF_W-1:0] a_ct_reg [2];
    logic signed [HALF_W-1:0] a_cx_reg, a_cy_reg;
    logic signed [HALF_W:0]   a_w_reg, a_h_reg;

    // Stage B: products.
    logic                     b_valid_reg;
    meta_t                    b_meta_reg;
    logic signed [PROD_W-1:0] b_pc_reg [2];
    logic signed [PROD_W-1:0] b_pcy_reg [2];
    logic signed [PROD_W-1:0] b_pw_reg [2];
    logic signed [PROD_W-1:0] b_ph_reg [2];
    logic signed [COEF_W-1:0] b_ct_reg [2];
    logic signed [PROD_W-1:0] b_pc_next [2];
    logic signed [PROD_W-1:0] b_pcy_next [2];
    logic signed [PROD_W-1:0] b_pw_next [2];
    logic signed [PROD_W-1:0] b_ph_next [2];

    // Stage C: centre term.
    logic                     c_valid_reg;
    meta_t                    c_meta_reg;
    logic signed [SUM_W-1:0]  c_base_reg [2];
    logic signed [PROD_W-1:0] c_pw_reg [2];
    logic signed [PROD_W-1:0] c_ph_reg [2];
    logic signed [SUM_W-1:0]  c_base_next [2];
    logic signed [SUM_W-1:0]  t16 [2];

    // Stage D: corner sums, presented to the queue.
    logic                    d_valid_reg;
    cmd_t                    d_cmd_reg, d_cmd_next;
    logic signed [SUM_W-1:0] corner [2][4];

    assign en            = !d_valid_reg || q_status.push_ready;
    assign s_axis_tready = en;
    assign accept        = s_axis_tvalid && en;

    assign in_lay = s_axis_tdata[15:0];
    assign in_mat = s_axis_tdata[31:16];
    assign in_eof = s_axis_tlast;

    always_comb
    begin
        drop     = (vbase_reg >= VERT_LIMIT);
        key_diff = (in_mat != cur_mat_reg) || (in_lay != cur_lay_reg);
        close    = !drop && open_reg && key_diff;

        first_mid = close ? (first_reg + count_reg) : first_reg;
        if (drop) begin
            count_mid = count_reg;
        end
        else begin
            count_mid = (close ? {CNT_W{1'b0}} : count_reg) + IDX_PER_SPRITE;
        end
        vbase_mid = drop ? vbase_reg : (vbase_reg + VERTS_PER_SPRITE);
        mat_mid   = drop ? cur_mat_reg : in_mat;
        lay_mid   = drop ? cur_lay_reg : in_lay;
        open_mid  = open_reg || !drop;
        ovf_mid   = ovf_reg || drop;

        meta_new.has_close       = close;
        meta_new.has_sprite      = !drop;
        meta_new.has_eof         = in_eof && open_mid;
        meta_new.ovf             = ovf_mid;
        meta_new.close_rec.mat   = cur_mat_reg;
        meta_new.close_rec.lay   = cur_lay_reg;
        meta_new.close_rec.first = first_reg;
        meta_new.close_rec.count = count_reg;
        meta_new.eof_rec.mat     = mat_mid;
        meta_new.eof_rec.lay     = lay_mid;
        meta_new.eof_rec.first   = first_mid;
        meta_new.eof_rec.count   = count_mid;
        meta_new.vbase           = vbase_reg;
        meta_new.uv_px           = s_axis_tdata[303:288];
        meta_new.uv_py           = s_axis_tdata[319:304];
        meta_new.uv_ex           = s_axis_tdata[335:320];
        meta_new.uv_ey           = s_axis_tdata[351:336];

        // A dropped sprite that does not end the frame causes nothing downstream.
        a_valid_next = accept && (!drop || (in_eof && open_mid));

        cur_mat_next = cur_mat_reg;
        cur_lay_next = cur_lay_reg;
        open_next    = open_reg;
        first_next   = first_reg;
        count_next   = count_reg;
        vbase_next   = vbase_reg;
        ovf_next     = ovf_reg;
        if (accept) begin
            cur_mat_next = mat_mid;
            cur_lay_next = lay_mid;
            if (in_eof) begin
                open_next  = 1'b0;
                first_next = '0;
                count_next = '0;
                vbase_next = '0;
                ovf_next   = 1'b0;
            end
            else begin
                open_next  = open_mid;
                first_next = first_mid;
                count_next = count_mid;
                vbase_next = vbase_mid;
                ovf_next   = ovf_mid;
            end
        end
    end

    always_comb
    begin
        for (int ax = 0; ax < 2; ax++) begin
            b_pc_next[ax]  = a_cl_reg[ax] * a_cx_reg;
            b_pcy_next[ax] = a_cm_reg[ax] * a_cy_reg;
            b_pw_next[ax]  = a_cl_reg[ax] * a_w_reg;
            b_ph_next[ax]  = a_cm_reg[ax] * a_h_reg;
        end
    end

    // Translation in Q.20 with the rounding half already added.
    always_comb
    begin
        for (int ax = 0; ax < 2; ax++) begin
            t16[ax] = {{(SUM_W-COEF_W-FRAC_SHIFT){b_ct_reg[ax][COEF_W-1]}}, b_ct_reg[ax],
                       4'b1000};
            c_base_next[ax] = t16[ax] - b_pc_reg[ax] - b_pcy_reg[ax];
        end
    end

    always_comb
    begin
        for (int ax = 0; ax < 2; ax++) begin
            corner[ax][0] = c_base_reg[ax];
            corner[ax][1] = c_base_reg[ax] + c_ph_reg[ax];
            corner[ax][2] = c_base_reg[ax] + c_pw_reg[ax] + c_ph_reg[ax];
            corner[ax][3] = c_base_reg[ax] + c_pw_reg[ax];
        end
        d_cmd_next.meta = c_meta_reg;
        for (int v = 0; v < 4; v++) begin
            d_cmd_next.sum_x[v] = corner[0][v];
            d_cmd_next.sum_y[v] = corner[1][v];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cur_mat_reg <= '0;
            cur_lay_reg <= '0;
            open_reg    <= 1'b0;
            first_reg   <= '0;
            count_reg   <= '0;
            vbase_reg   <= '0;
            ovf_reg     <= 1'b0;
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else begin
            cur_mat_reg <= cur_mat_next;
            cur_lay_reg <= cur_lay_next;
            open_reg    <= open_next;
            first_reg   <= first_next;
            count_reg   <= count_next;
            vbase_reg   <= vbase_next;
            ovf_reg     <= ovf_next;
            if (en) begin
                a_valid_reg <= a_valid_next;
                b_valid_reg <= a_valid_reg;
                c_valid_reg <= b_valid_reg;
                d_valid_reg <= c_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            a_meta_reg  <= meta_new;
            a_cl_reg[0] <= s_axis_tdata[63:32];
            a_cm_reg[0] <= s_axis_tdata[95:64];
            a_ct_reg[0] <= s_axis_tdata[127:96];
            a_cl_reg[1] <= s_axis_tdata[159:128];
            a_cm_reg[1] <= s_axis_tdata[191:160];
            a_ct_reg[1] <= s_axis_tdata[223:192];
            a_cx_reg    <= s_axis_tdata[239:224];
            a_cy_reg    <= s_axis_tdata[255:240];
            a_w_reg     <= {1'b0, s_axis_tdata[271:256]};
            a_h_reg     <= {1'b0, s_axis_tdata[287:272]};

            b_meta_reg <= a_meta_reg;
            c_meta_reg <= b_meta_reg;
            for (int ax = 0; ax < 2; ax++) begin
                b_pc_reg[ax]   <= b_pc_next[ax];
                b_pcy_reg[ax]  <= b_pcy_next[ax];
                b_pw_reg[ax]   <= b_pw_next[ax];
                b_ph_reg[ax]   <= b_ph_next[ax];
                b_ct_reg[ax]   <= a_ct_reg[ax];
                c_base_reg[ax] <= c_base_next[ax];
                c_pw_reg[ax]   <= b_pw_reg[ax];
                c_ph_reg[ax]   <= b_ph_reg[ax];
            end
            d_cmd_reg <= d_cmd_next;
        end
    end

    assign push     = d_valid_reg;
    assign push_cmd = d_cmd_reg;

endmodule

// ===== rtl/core/sqbe_cmd_queue.sv =====
// Short command queue that decouples the intake from the result expander.
module sqbe_cmd_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  sqbe_pkg::cmd_t      push_cmd,
    input  logic                pop,
    output sqbe_pkg::cmd_t      head_cmd,
    output sqbe_pkg::q_status_t status
);
    import sqbe_pkg::*;

    cmd_t              entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign status.push_ready = (count_reg != QCNT_W'(QDEPTH));
    assign status.head_valid = (count_reg != '0);
    assign head_cmd          = entry_reg[rd_ptr_reg];

    assign do_push = push && status.push_ready;
    assign do_pop  = pop && status.head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== rtl/core/sqbe_back.sv =====
// Result expander: walks each command through its result slots into the output register.
module sqbe_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  sqbe_pkg::cmd_t                  head_cmd,
    input  sqbe_pkg::q_status_t             q_status,
    output logic                            pop,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [sqbe_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output logic [sqbe_pkg::KIND_W-1:0]     m_axis_tuser,
    output logic                            m_axis_tlast
);
    import sqbe_pkg::*;

    logic                  out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg;
    kind_t                 out_kind_reg;
    logic                  out_last_reg;

    logic [STEP_W-1:0] step_reg, step_next;
    logic              fresh_reg, fresh_next;

    logic              load;
    logic [STEP_W-1:0] first_step, eff_step, nxt_step;
    logic              nxt_done;
    logic [STEP_W-1:0] vert_rel, idx_rel;
    logic [1:0]        vi, ioff;
    logic              use_ex, use_ey;
    meta_t             m;
    batch_rec_t        rec;

    kind_t             res_kind;
    logic [POS_W-1:0]  res_pos_x, res_pos_y;
    logic [UV_W-1:0]   res_uv_x, res_uv_y;
    logic [IDX_W-1:0]  res_index;
    batch_rec_t        res_rec;
    logic [OUT_DATA_W-1:0] res_data;
    logic [CNT_W-1:0]  idx_sum;

    assign m    = head_cmd.meta;
    assign load = q_status.head_valid && (!out_valid_reg || m_axis_tready);

    // Slot sequencing.
    always_comb
    begin
        if (m.has_close) begin
            first_step = STEP_CLOSE;
        end
        else if (m.has_sprite) begin
            first_step = STEP_VERT0;
        end
        else begin
            first_step = STEP_EOF;
        end
        eff_step = fresh_reg ? first_step : step_reg;

        nxt_step = eff_step + 1'b1;
        nxt_done = 1'b0;
        priority if (eff_step == STEP_CLOSE) begin
            nxt_step = m.has_sprite ? STEP_VERT0 : STEP_EOF;
            nxt_done = !m.has_sprite && !m.has_eof;
        end
        else if (eff_step == STEP_IDX_LAST) begin
            nxt_step = STEP_EOF;
            nxt_done = !m.has_eof;
        end
        else if (eff_step >= STEP_EOF) begin
            nxt_done = 1'b1;
        end
        else begin
            nxt_done = 1'b0;
        end
    end

    // Result fields of the current slot.
    always_comb
    begin
        vert_rel = eff_step - STEP_VERT0;
        idx_rel  = eff_step - STEP_IDX0;
        vi       = vert_rel[1:0];
        ioff     = ix_offset(idx_rel[2:0]);
        use_ex   = vi[1];
        use_ey   = vi[1] ^ vi[0];
        rec      = (eff_step == STEP_CLOSE) ? m.close_rec : m.eof_rec;
        idx_sum  = m.vbase + {{(CNT_W-2){1'b0}}, ioff};

        res_pos_x = '0;
        res_pos_y = '0;
        res_uv_x  = '0;
        res_uv_y  = '0;
        res_index = '0;
        res_rec   = '0;
        priority if ((eff_step == STEP_CLOSE) || (eff_step >= STEP_EOF)) begin
            res_kind = KIND_BATCH;
            res_rec  = rec;
        end
        else if (eff_step < STEP_IDX0) begin
            res_kind  = KIND_VERTEX;
            res_pos_x = sat_pos(head_cmd.sum_x[vi]);
            res_pos_y = sat_pos(head_cmd.sum_y[vi]);
            res_uv_x  = uv_sum(m.uv_px, m.uv_ex, use_ex);
            res_uv_y  = uv_sum(m.uv_py, m.uv_ey, use_ey);
        end
        else begin
            res_kind  = KIND_INDEX;
            res_index = idx_sum[IDX_W-1:0];
        end

        res_data = {3'b000, m.ovf, res_rec.count, res_rec.first, res_rec.lay, res_rec.mat,
                    res_index, res_uv_y, res_uv_x, res_pos_y, res_pos_x};
    end

    always_comb
    begin
        pop            = load && nxt_done;
        step_next      = step_reg;
        fresh_next     = fresh_reg;
        out_valid_next = out_valid_reg;
        if (load) begin
            out_valid_next = 1'b1;
            step_next      = nxt_step;
            fresh_next     = nxt_done;
        end
        else if (m_axis_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
            step_reg      <= STEP_CLOSE;
            fresh_reg     <= 1'b1;
        end
        else begin
            out_valid_reg <= out_valid_next;
            step_reg      <= step_next;
            fresh_reg     <= fresh_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            out_data_reg <= res_data;
            out_kind_reg <= res_kind;
            out_last_reg <= nxt_done;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

// ===== rtl/core/sprite_quad_batch_expander.sv =====
// Top level of the sprite quad batch expander: intake, command queue and result expander.
//
// Sprites arrive already sorted by layer and material, one per input transaction, with
// tlast marking the last sprite of a frame. Each sprite becomes four vertex transactions
// (Q16.16 positions of the transformed corners, rounded to nearest and saturated, plus
// uv coordinates) and six index transactions; a change of layer or material first emits
// a batch record closing the previous batch, and the end of a frame emits the record of
// the open batch last and clears the frame counters. Past 16384 sprites in a frame, further
// sprites are dropped and the overflow bit is set on later results of that frame. The
// output side carries one result per clock while m_axis_tready is high, and a sprite yields
// 10 to 12 results (1 for a dropped sprite that ends a frame, none for other dropped ones);
// that output port sets the sustained rate. The intake classifies a sprite in the cycle
// it is taken and runs the corner products through a four-stage pipeline into a
// two-entry command queue, so it keeps taking sprites while the output drains until
// the queue is full; a sprite passes stages A to D and the queue to the output register.
module sprite_quad_batch_expander (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // layer, material, xform_xx, xform_xy, xform_xt, xform_yx, xform_yy, xform_yt,
    // center_packed, size_packed, uv_region (lowest bits first)
    input  logic [sqbe_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    input  logic                            s_axis_tlast,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // pos_x, pos_y, uv_x, uv_y, index_value, batch_material, batch_layer,
    // batch_first_index, batch_index_count, overflow, zero padding (lowest bits first)
    output logic [sqbe_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // kind: 0 vertex, 1 index, 2 batch record
    output logic [sqbe_pkg::KIND_W-1:0]     m_axis_tuser,
    output logic                            m_axis_tlast
);
    import sqbe_pkg::*;

    logic      push;
    cmd_t      push_cmd;
    logic      pop;
    cmd_t      head_cmd;
    q_status_t q_stat;

    // Intake: classification against the open batch and the corner arithmetic.
    sqbe_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .push          (push),
        .push_cmd      (push_cmd),
        .q_status      (q_stat)
    );

    // Commands wait here so either side can stall without stopping the other until the queue runs full or empty.
    sqbe_cmd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .status   (q_stat)
    );

    // Expander: one result per cycle into the output register while a command waits and the output is taken.
    sqbe_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_cmd      (head_cmd),
        .q_status      (q_stat),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

`ifndef SYNTH
    // A full queue with a command waiting must hold off the intake.
    a_full_stalls_intake: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !q_stat.push_ready) |-> !s_axis_tready)
        else $error("intake ready while the command queue is full");

    // The expander never retires a command the queue does not hold.
    a_pop_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_stat.head_valid)
        else $error("command popped from an empty queue");

    // Vertices are always followed by their indices, so a vertex never ends a sprite.
    a_vertex_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser == KIND_VERTEX)) |-> !m_axis_tlast)
        else $error("vertex transaction marked as the last result of a sprite");
`endif

endmodule
